### design/tpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants of the three point quadratic fit pipeline.
// ----------------------------------------------------------------------------
package tpq_pkg;

	// width of every coordinate and coefficient word
	localparam int DATA_W = 32;

	// limb width of the split multipliers
	localparam int LIMB_W = 32;

	// register stages of one split multiplier
	localparam int MUL_LAT = 3;

	// register stages of one divider: setup, one per quotient bit, round
	localparam int DIV_LAT = DATA_W + 3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	typedef enum logic [1:0] {
		MODE_QUAD  = 2'd0,
		MODE_LINE  = 2'd1,
		MODE_CONST = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x_low;
		logic signed [DATA_W-1:0] y_low;
		logic signed [DATA_W-1:0] x_mid;
		logic signed [DATA_W-1:0] y_mid;
		logic signed [DATA_W-1:0] x_high;
		logic signed [DATA_W-1:0] y_high;
		logic                     low_repeated;
		logic                     high_repeated;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] coef_a;
		logic signed [DATA_W-1:0] coef_b;
		logic signed [DATA_W-1:0] coef_c;
		logic [1:0]               status;
	} out_t;

endpackage

### design/tpq_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_delay
// Register line that keeps side data aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
module tpq_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

### design/tpq_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_mul
// Signed multiplier split into limb products: magnitude, partials, sum.
// ----------------------------------------------------------------------------
module tpq_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);

	localparam int LW = tpq_pkg::LIMB_W;
	localparam int NA = (AW + LW - 1) / LW;
	localparam int NB = (BW + LW - 1) / LW;
	localparam int PW = AW + BW;

	logic [AW-1:0]      aabs;
	logic [BW-1:0]      babs;
	logic [NA*LW-1:0]   aabs_s1;
	logic [NB*LW-1:0]   babs_s1;
	logic               neg_s1;
	logic               neg_s2;
	logic [2*LW-1:0]    pp_s2 [NA][NB];
	logic [PW-1:0]      acc;
	logic [PW-1:0]      p_s3;

	assign aabs = a[AW-1] ? $unsigned(-a) : $unsigned(a);
	assign babs = b[BW-1] ? $unsigned(-b) : $unsigned(b);

	always_ff @(posedge clk) begin
		if (en) begin
			aabs_s1 <= (NA*LW)'(aabs);
			babs_s1 <= (NB*LW)'(babs);
			neg_s1  <= a[AW-1] ^ b[BW-1];
			neg_s2  <= neg_s1;
		end
	end

	for (genvar i = 0; i < NA; i++) begin : g_ra
		for (genvar j = 0; j < NB; j++) begin : g_rb
			always_ff @(posedge clk) begin
				if (en) begin
					pp_s2[i][j] <= aabs_s1[i*LW +: LW] * babs_s1[j*LW +: LW];
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (PW'(pp_s2[i][j]) << (LW * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= neg_s2 ? -acc : acc;
		end
	end

	assign p = $signed(p_s3);

endmodule

### design/tpq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_div
// Pipelined restoring divider, one quotient bit per stage, rounded to
// nearest with ties away from zero and saturated to QW signed bits.
// ----------------------------------------------------------------------------
module tpq_div #(
	parameter int QW   = 32,
	parameter int NW   = 99,
	parameter int DENW = 99
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [NW-1:0]   num,
	input  logic signed [DENW-1:0] den,
	output logic signed [QW-1:0]   quo,
	output logic                   sat
);

	localparam int NS = QW + 1;
	localparam int CW = (NW > DENW + NS) ? NW : DENW + NS;
	localparam logic [NS:0] MAXP = {3'b000, {(QW-1){1'b1}}};
	localparam logic [NS:0] MAXN = {3'b001, {(QW-1){1'b0}}};

	logic [NW-1:0]   nabs;
	logic [DENW-1:0] dabs;
	logic            ovf;

	logic [CW-1:0]   rem_s [NS+1];
	logic [DENW-1:0] dv_s  [NS+1];
	logic [NS-1:0]   quo_s [NS+1];
	logic            neg_s [NS+1];
	logic            ovf_s [NS+1];

	logic            rnd;
	logic [NS:0]     qm;
	logic            sat_n;
	logic [QW-1:0]   val_n;
	logic [QW-1:0]   quo_q;
	logic            sat_q;

	assign nabs = num[NW-1] ? $unsigned(-num) : $unsigned(num);
	assign dabs = den[DENW-1] ? $unsigned(-den) : $unsigned(den);
	// quotient would need more than NS bits
	assign ovf  = CW'(nabs) >= (CW'(dabs) << NS);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= CW'(nabs);
			dv_s[0]  <= dabs;
			quo_s[0] <= '0;
			neg_s[0] <= num[NW-1] ^ den[DENW-1];
			ovf_s[0] <= ovf;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_bit
		localparam int SH = NS - 1 - k;
		logic [CW:0] trial;
		logic        take;

		assign trial = {1'b0, rem_s[k]} - ((CW+1)'(dv_s[k]) << SH);
		assign take  = ~trial[CW];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? trial[CW-1:0] : rem_s[k];
				quo_s[k+1] <= {quo_s[k][NS-2:0], take};
				dv_s[k+1]  <= dv_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign rnd = {rem_s[NS], 1'b0} >= (CW+1)'(dv_s[NS]);
	assign qm  = (NS+1)'(quo_s[NS]) + (NS+1)'(rnd);

	always_comb begin
		sat_n = ovf_s[NS] | (neg_s[NS] ? (qm > MAXN) : (qm > MAXP));
		if (sat_n) begin
			val_n = neg_s[NS] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
		end else begin
			val_n = neg_s[NS] ? -qm[QW-1:0] : qm[QW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= val_n;
			sat_q <= sat_n;
		end
	end

	assign quo = $signed(quo_q);
	assign sat = sat_q;

endmodule

### design/three_point_quadratic_fit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_point_quadratic_fit_top
// Fits y = a*x^2 + b*x + c through three points, a line through two of them
// at one grid edge or a constant at both, in exact fixed point with one final rounding.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              word
//  req      in   req_valid/req_ready    tpq_pkg::in_t  (three points, flags)
//  rsp      out  rsp_valid/rsp_ready    tpq_pkg::out_t (a, b, c, status)
//
//  One word per cycle sustained while no result waits. The stages in order:
//  input stage, two split multiplier levels, a numerator stage, and three
//  restoring dividers that resolve one quotient bit a stage.
//  Reset clears only the stage valid bits. A waiting result freezes the whole
//  pipeline, which holds every stage and drops req_ready until it is taken.
//
module three_point_quadratic_fit_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tpq_pkg::in_t   req_word,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tpq_pkg::out_t  rsp_word
);

	localparam int W    = tpq_pkg::DATA_W;
	localparam int DW1  = W + 1;          // coordinate difference / sum
	localparam int TW   = 2 * W + 1;      // y times difference
	localparam int MW   = 2 * W;          // x times x
	localparam int QDW  = 2 * W + 2;      // d12 * d13
	localparam int UW   = 3 * W + 2;      // t * s
	localparam int VW   = 4 * W + 1;      // t * m
	localparam int DENW = 3 * W + 3;
	localparam int NAW  = 2 * W + 3 + 2 * FRAC_BITS;
	localparam int NBW  = 3 * W + 4 + FRAC_BITS;
	localparam int NCW  = 4 * W + 3;
	localparam int ML   = tpq_pkg::MUL_LAT;
	localparam int LAT  = 2 + 2 * ML + tpq_pkg::DIV_LAT;

	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

	// global advance: everything moves unless a result waits
	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv       = ~rsp_valid | rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], req_valid};
		end
	end

	// ---------------- stage 1: differences, case select ----------------
	logic signed [DW1-1:0] x1e, x2e, x3e;
	logic signed [DW1-1:0] d12, d13, d23, s12, s13, s23;
	logic signed [W-1:0]   xp, yp, xq, yq;
	tpq_pkg::mode_t        mode_n;
	logic                  zero_n;
	logic signed [W-1:0]   t1a_n, t2a_n, t3a_n;
	logic signed [DW1-1:0] t1b_n, t2b_n, t3b_n;

	assign x1e = DW1'(req_word.x_low);
	assign x2e = DW1'(req_word.x_mid);
	assign x3e = DW1'(req_word.x_high);
	assign d12 = x1e - x2e;
	assign d13 = x1e - x3e;
	assign d23 = x2e - x3e;
	assign s12 = x1e + x2e;
	assign s13 = x1e + x3e;
	assign s23 = x2e + x3e;

	// line through (p) and (q): centre/high at the low edge, low/centre at the high edge
	assign xp = req_word.low_repeated ? req_word.x_mid  : req_word.x_low;
	assign yp = req_word.low_repeated ? req_word.y_mid  : req_word.y_low;
	assign xq = req_word.low_repeated ? req_word.x_high : req_word.x_mid;
	assign yq = req_word.low_repeated ? req_word.y_high : req_word.y_mid;

	always_comb begin
		case ({req_word.low_repeated, req_word.high_repeated})
			2'b11:   mode_n = tpq_pkg::MODE_CONST;
			2'b10,
			2'b01:   mode_n = tpq_pkg::MODE_LINE;
			default: mode_n = tpq_pkg::MODE_QUAD;
		endcase
	end

	always_comb begin
		case (mode_n)
			tpq_pkg::MODE_LINE: begin
				// first multiplier level forms yq*xp and yp*xq
				zero_n = (xp == xq);
				t1a_n  = yq;
				t1b_n  = DW1'(xp);
				t2a_n  = yp;
				t2b_n  = DW1'(xq);
				t3a_n  = '0;
				t3b_n  = '0;
			end
			default: begin
				zero_n = (mode_n == tpq_pkg::MODE_QUAD) &&
					((d12 == '0) || (d13 == '0) || (d23 == '0));
				t1a_n  = req_word.y_low;
				t1b_n  = d23;
				t2a_n  = req_word.y_mid;
				t2b_n  = d13;
				t3a_n  = req_word.y_high;
				t3b_n  = d12;
			end
		endcase
	end

	logic signed [W-1:0]   t1a_s1, t2a_s1, t3a_s1;
	logic signed [DW1-1:0] t1b_s1, t2b_s1, t3b_s1;
	logic signed [W-1:0]   x1_s1, x2_s1, x3_s1, ylow_s1;
	logic signed [DW1-1:0] d12_s1, d13_s1, d23_s1, s12_s1, s13_s1, s23_s1;
	logic signed [DW1-1:0] dl_s1, nbl_s1;
	tpq_pkg::mode_t        mode_s1;
	logic                  zero_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			t1a_s1  <= t1a_n;
			t2a_s1  <= t2a_n;
			t3a_s1  <= t3a_n;
			t1b_s1  <= t1b_n;
			t2b_s1  <= t2b_n;
			t3b_s1  <= t3b_n;
			x1_s1   <= req_word.x_low;
			x2_s1   <= req_word.x_mid;
			x3_s1   <= req_word.x_high;
			ylow_s1 <= req_word.y_low;
			d12_s1  <= d12;
			d13_s1  <= d13;
			d23_s1  <= d23;
			s12_s1  <= s12;
			s13_s1  <= s13;
			s23_s1  <= s23;
			dl_s1   <= DW1'(xp) - DW1'(xq);
			nbl_s1  <= DW1'(yp) - DW1'(yq);
			mode_s1 <= mode_n;
			zero_s1 <= zero_n;
		end
	end

	// ---------------- multiplier level 1 ----------------
	logic signed [TW-1:0]  t1, t2, t3;
	logic signed [MW-1:0]  m23, m13, m12;
	logic signed [QDW-1:0] q12;

	tpq_mul #(.AW(W), .BW(DW1)) u_mt1 (.clk, .en(adv), .a(t1a_s1), .b(t1b_s1), .p(t1));
	tpq_mul #(.AW(W), .BW(DW1)) u_mt2 (.clk, .en(adv), .a(t2a_s1), .b(t2b_s1), .p(t2));
	tpq_mul #(.AW(W), .BW(DW1)) u_mt3 (.clk, .en(adv), .a(t3a_s1), .b(t3b_s1), .p(t3));
	tpq_mul #(.AW(W), .BW(W)) u_mm23 (.clk, .en(adv), .a(x2_s1), .b(x3_s1), .p(m23));
	tpq_mul #(.AW(W), .BW(W)) u_mm13 (.clk, .en(adv), .a(x1_s1), .b(x3_s1), .p(m13));
	tpq_mul #(.AW(W), .BW(W)) u_mm12 (.clk, .en(adv), .a(x1_s1), .b(x2_s1), .p(m12));
	tpq_mul #(.AW(DW1), .BW(DW1)) u_mq (.clk, .en(adv), .a(d12_s1), .b(d13_s1), .p(q12));

	logic [4*DW1-1:0] sd_d;
	logic signed [DW1-1:0] s12_d, s13_d, s23_d, d23_d;

	tpq_delay #(.WIDTH(4*DW1), .DEPTH(ML)) u_dly_sd (
		.clk, .en(adv),
		.d({s12_s1, s13_s1, s23_s1, d23_s1}),
		.q(sd_d)
	);
	assign {s12_d, s13_d, s23_d, d23_d} = sd_d;

	// numerator of a; in the line case it is yq*xp - yp*xq, the numerator of c
	logic signed [TW+1:0] na_raw;
	logic [TW+1:0]        na_dq;
	assign na_raw = (TW+2)'(t1) - (TW+2)'(t2) + (TW+2)'(t3);

	tpq_delay #(.WIDTH(TW+2), .DEPTH(ML)) u_dly_na (
		.clk, .en(adv), .d(na_raw), .q(na_dq)
	);

	// ---------------- multiplier level 2 ----------------
	logic signed [UW-1:0]   u1, u2, u3;
	logic signed [VW-1:0]   v1, v2, v3;
	logic signed [DENW-1:0] den_q;

	tpq_mul #(.AW(TW), .BW(DW1)) u_mu1 (.clk, .en(adv), .a(t1), .b(s23_d), .p(u1));
	tpq_mul #(.AW(TW), .BW(DW1)) u_mu2 (.clk, .en(adv), .a(t2), .b(s13_d), .p(u2));
	tpq_mul #(.AW(TW), .BW(DW1)) u_mu3 (.clk, .en(adv), .a(t3), .b(s12_d), .p(u3));
	tpq_mul #(.AW(TW), .BW(MW)) u_mv1 (.clk, .en(adv), .a(t1), .b(m23), .p(v1));
	tpq_mul #(.AW(TW), .BW(MW)) u_mv2 (.clk, .en(adv), .a(t2), .b(m13), .p(v2));
	tpq_mul #(.AW(TW), .BW(MW)) u_mv3 (.clk, .en(adv), .a(t3), .b(m12), .p(v3));
	tpq_mul #(.AW(QDW), .BW(DW1)) u_mden (.clk, .en(adv), .a(q12), .b(d23_d), .p(den_q));

	logic [2+2*DW1-1:0]    ln_d;
	logic [1:0]            mode_cq;
	logic signed [DW1-1:0] dl_d, nbl_d;

	tpq_delay #(.WIDTH(2+2*DW1), .DEPTH(2*ML)) u_dly_ln (
		.clk, .en(adv),
		.d({mode_s1, dl_s1, nbl_s1}),
		.q(ln_d)
	);
	assign {mode_cq, dl_d, nbl_d} = ln_d;

	// ---------------- numerator stage ----------------
	logic signed [UW+1:0]   nb_raw;
	logic signed [VW+1:0]   nc_raw;
	logic signed [NAW-1:0]  na_n, na_s8;
	logic signed [NBW-1:0]  nb_n, nb_s8;
	logic signed [NCW-1:0]  nc_n, nc_s8;
	logic signed [DENW-1:0] den_n, den_s8;

	assign nb_raw = (UW+2)'(u2) - (UW+2)'(u1) - (UW+2)'(u3);
	assign nc_raw = (VW+2)'(v1) - (VW+2)'(v2) + (VW+2)'(v3);

	always_comb begin
		case (tpq_pkg::mode_t'(mode_cq))
			tpq_pkg::MODE_LINE: begin
				na_n  = '0;
				nb_n  = NBW'(nbl_d) << FRAC_BITS;
				nc_n  = NCW'($signed(na_dq));
				den_n = DENW'(dl_d);
			end
			default: begin
				na_n  = NAW'($signed(na_dq)) << (2 * FRAC_BITS);
				nb_n  = NBW'(nb_raw) << FRAC_BITS;
				nc_n  = NCW'(nc_raw);
				den_n = den_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			na_s8  <= na_n;
			nb_s8  <= nb_n;
			nc_s8  <= nc_n;
			den_s8 <= den_n;
		end
	end

	// ---------------- dividers ----------------
	logic signed [W-1:0] qa, qb, qc;
	logic                sa, sb, sc;

	tpq_div #(.QW(W), .NW(NAW), .DENW(DENW)) u_dva (
		.clk, .en(adv), .num(na_s8), .den(den_s8), .quo(qa), .sat(sa)
	);
	tpq_div #(.QW(W), .NW(NBW), .DENW(DENW)) u_dvb (
		.clk, .en(adv), .num(nb_s8), .den(den_s8), .quo(qb), .sat(sb)
	);
	tpq_div #(.QW(W), .NW(NCW), .DENW(DENW)) u_dvc (
		.clk, .en(adv), .num(nc_s8), .den(den_s8), .quo(qc), .sat(sc)
	);

	// case, zero divisor and low y ride along to the output
	logic [2+1+W-1:0]    tail_d;
	logic [1:0]          mode_oq;
	logic                zero_o;
	logic signed [W-1:0] ylow_o;

	tpq_delay #(.WIDTH(3+W), .DEPTH(LAT-1)) u_dly_tail (
		.clk, .en(adv),
		.d({mode_s1, zero_s1, ylow_s1}),
		.q(tail_d)
	);
	assign {mode_oq, zero_o, ylow_o} = tail_d;

	always_comb begin
		case (tpq_pkg::mode_t'(mode_oq))
			tpq_pkg::MODE_CONST: begin
				rsp_word.coef_a = '0;
				rsp_word.coef_b = '0;
				rsp_word.coef_c = ylow_o;
				rsp_word.status = tpq_pkg::ST_OK;
			end
			default: begin
				if (zero_o) begin
					rsp_word.coef_a = '0;
					rsp_word.coef_b = '0;
					rsp_word.coef_c = '0;
					rsp_word.status = tpq_pkg::ST_ZERO;
				end else begin
					rsp_word.coef_a = qa;
					rsp_word.coef_b = qb;
					rsp_word.coef_c = qc;
					rsp_word.status = (sa | sb | sc) ? tpq_pkg::ST_SAT : tpq_pkg::ST_OK;
				end
			end
		endcase
	end

	// ---------------- checks ----------------
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status == tpq_pkg::ST_ZERO |->
			rsp_word.coef_a == '0 && rsp_word.coef_b == '0 && rsp_word.coef_c == '0)
		else $error("zero divisor word carries nonzero coefficients");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status == tpq_pkg::ST_SAT |->
			rsp_word.coef_a == CMAX || rsp_word.coef_a == CMIN ||
			rsp_word.coef_b == CMAX || rsp_word.coef_b == CMIN ||
			rsp_word.coef_c == CMAX || rsp_word.coef_c == CMIN)
		else $error("saturated status without a clamped coefficient");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("stage valids moved during a stall");

endmodule
